FILE: hdl/qmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmd_pkg: shared types and constants for the quadrature motor drive
// Commands, register indexes, reset values, the quadrature step table and the
// control bundle that goes to the position and drive units.
// ----------------------------------------------------------------------------
package qmd_pkg;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_TARGET = 2'd3
	} cmd_t;

	localparam logic REG_RAMP_STEP = 1'b0;
	localparam logic REG_WINDOW_US = 1'b1;

	localparam logic [7:0]  RAMP_STEP_RESET = 8'd10;
	localparam logic [31:0] WINDOW_US_RESET = 32'd500000;

	localparam logic signed [8:0] LEVEL_MIN = -9'sd255;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 128;

	// indexed by next_phase*4 + previous_phase
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd0, 2'sd1,
		2'sd1, 2'sd0, -2'sd1, 2'sd0,
		2'sd0, 2'sd1, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd1, 2'sd0
	};

	typedef struct packed {
		logic        fire;
		cmd_t        cmd;
	} qmd_ctrl_t;

	typedef struct packed {
		logic signed [8:0] target;
		logic [31:0]       now_us;
		logic              chan_b;
		logic              chan_a;
	} qmd_item_t;

	// A/B 11 -> 0, 10 -> 1, 00 -> 2, 01 -> 3
	function automatic logic [1:0] phase_of(input logic a, input logic b);
		logic [1:0] p;
		if (a && b) begin
			p = 2'd0;
		end else if (a) begin
			p = 2'd1;
		end else if (!b) begin
			p = 2'd2;
		end else begin
			p = 2'd3;
		end
		return p;
	endfunction

endpackage : qmd_pkg
`default_nettype wire

FILE: hdl/qmd_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmd_position: encoder position counter and velocity window
// Tracks the quadrature phase, steps the wrapping position and latches the
// position change and elapsed time once a window has passed.
// ----------------------------------------------------------------------------
module qmd_position
	import qmd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qmd_ctrl_t          ctrl,
	input  wire logic               chan_a,
	input  wire logic               chan_b,
	input  wire logic [31:0]        now_us,
	input  wire logic [31:0]        window_us,
	output logic signed [31:0]      position,
	output logic signed [31:0]      window_delta,
	output logic [31:0]             window_elapsed
);

	logic [1:0]  phase_q;
	logic [31:0] step_count_q;
	logic [31:0] win_count_q;
	logic [31:0] win_time_q;
	logic [31:0] delta_q;
	logic [31:0] elapsed_q;

	logic [1:0]         next_phase;
	logic signed [1:0]  step;
	logic [31:0]        elapsed;

	always_comb begin
		next_phase = phase_of(chan_a, chan_b);
		step       = STEP_TABLE[{next_phase, phase_q}];
		elapsed    = now_us - win_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			step_count_q <= '0;
			win_count_q  <= '0;
			win_time_q   <= '0;
			delta_q      <= '0;
			elapsed_q    <= '0;
		end else if (ctrl.fire) begin
			case (ctrl.cmd)
				CMD_START: begin
					phase_q      <= next_phase;
					step_count_q <= '0;
					win_count_q  <= '0;
					win_time_q   <= now_us;
					delta_q      <= '0;
					elapsed_q    <= '0;
				end
				CMD_SAMPLE: begin
					phase_q      <= next_phase;
					step_count_q <= step_count_q + 32'(step);
				end
				CMD_TICK: begin
					if (elapsed > window_us) begin
						delta_q     <= step_count_q - win_count_q;
						elapsed_q   <= elapsed;
						win_count_q <= step_count_q;
						win_time_q  <= now_us;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign position       = step_count_q;
	assign window_delta   = delta_q;
	assign window_elapsed = elapsed_q;

endmodule : qmd_position
`default_nettype wire

FILE: hdl/qmd_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmd_drive: ramped bidirectional drive level
// Holds the drive goal, ramps the level toward it on each tick and splits the
// level into left and right PWM duties.
// ----------------------------------------------------------------------------
module qmd_drive
	import qmd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qmd_ctrl_t          ctrl,
	input  wire logic signed [8:0]  target,
	input  wire logic [7:0]         ramp_step,
	output logic signed [8:0]       drive_level,
	output logic [7:0]              pwm_left,
	output logic [7:0]              pwm_right
);

	logic signed [8:0] level_q;
	logic signed [8:0] goal_q;

	logic signed [10:0] lvl_w;
	logic signed [10:0] goal_w;
	logic signed [10:0] up;
	logic signed [10:0] dn;
	logic signed [8:0]  level_next;
	logic signed [8:0]  goal_next;
	logic signed [8:0]  neg_level;

	always_comb begin
		lvl_w  = 11'(level_q);
		goal_w = 11'(goal_q);
		up     = lvl_w + $signed({3'b000, ramp_step});
		dn     = lvl_w - $signed({3'b000, ramp_step});
		level_next = level_q;
		if (lvl_w < goal_w) begin
			level_next = (up < goal_w) ? up[8:0] : goal_q;
		end else if (lvl_w > goal_w) begin
			level_next = (dn > goal_w) ? dn[8:0] : goal_q;
		end
		goal_next = (target < LEVEL_MIN) ? LEVEL_MIN : target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			goal_q  <= '0;
		end else if (ctrl.fire) begin
			case (ctrl.cmd)
				CMD_TICK:   level_q <= level_next;
				CMD_TARGET: goal_q  <= goal_next;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		neg_level   = -level_q;
		drive_level = level_q;
		pwm_left    = level_q[8] ? neg_level[7:0] : 8'd0;
		pwm_right   = level_q[8] ? 8'd0 : level_q[7:0];
	end

endmodule : qmd_drive
`default_nettype wire

FILE: hdl/quadrature_motor_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_motor_drive: quadrature encoder counter with ramped PWM drive
// Input register, position and drive units whose state registers form the
// result, one result per command.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_axis   in   tuser: cmd; tdata: chan_a, chan_b, now_us, target
//  m_axis   out  tdata: position, window_delta, window_elapsed, drive_level,
//                pwm_left, pwm_right
//  cfg      in   0 ramp_step, 1 window_us
//
//  One command per cycle sustained while m_axis is ready; a command passes
//  the input register, then the state registers that carry its result to
//  m_axis.
//  Reset clears the valid flags and unit state and loads the register defaults; the input data register is not reset.
//  A stalled result holds; the input register keeps taking one more command.
// ----------------------------------------------------------------------------
module quadrature_motor_drive
	import qmd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // chan_a, chan_b, now_us, target, zero
	input  wire logic [1:0]            s_axis_tuser,  // cmd
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // position, window_delta,
	                                                  // window_elapsed, drive_level,
	                                                  // pwm_left, pwm_right, zero
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [31:0]           cfg_wdata
);

	logic        valid_s1;
	qmd_item_t   item_s1;
	cmd_t        cmd_s1;
	logic        out_valid_q;
	logic [7:0]  ramp_step_q;
	logic [31:0] window_us_q;

	logic        advance;
	qmd_ctrl_t   ctrl;

	logic signed [31:0] position;
	logic signed [31:0] window_delta;
	logic [31:0]        window_elapsed;
	logic signed [8:0]  drive_level;
	logic [7:0]         pwm_left;
	logic [7:0]         pwm_right;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign ctrl.fire     = advance;
	assign ctrl.cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= RAMP_STEP_RESET;
			window_us_q <= WINDOW_US_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAMP_STEP: ramp_step_q <= cfg_wdata[7:0];
				REG_WINDOW_US: window_us_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= s_axis_tdata[$bits(qmd_item_t)-1:0];
			cmd_s1  <= cmd_t'(s_axis_tuser);
		end
	end

	qmd_position u_position (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.chan_a         (item_s1.chan_a),
		.chan_b         (item_s1.chan_b),
		.now_us         (item_s1.now_us),
		.window_us      (window_us_q),
		.position       (position),
		.window_delta   (window_delta),
		.window_elapsed (window_elapsed)
	);

	qmd_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.target      (item_s1.target),
		.ramp_step   (ramp_step_q),
		.drive_level (drive_level),
		.pwm_left    (pwm_left),
		.pwm_right   (pwm_right)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, pwm_right, pwm_left, drive_level,
		window_elapsed, window_delta, position};

endmodule : quadrature_motor_drive
`default_nettype wire
